// File: hw/rtl/mrpt_pkg.sv
// Package for the Miller-Rabin prime test unit: widths and witness bases.
// Used by miller_rabin_prime_test_unit; depends on nothing.
`default_nettype none
package mrpt_pkg;
  localparam int DefNumBits = 64;
  localparam int BaseCount  = 12;
  localparam int BaseIdxW   = 4;

  function automatic logic [5:0] base_value(input logic [BaseIdxW-1:0] idx);
    logic [5:0] v;
    unique case (idx)
      4'd0:    v = 6'd2;
      4'd1:    v = 6'd3;
      4'd2:    v = 6'd5;
      4'd3:    v = 6'd7;
      4'd4:    v = 6'd11;
      4'd5:    v = 6'd13;
      4'd6:    v = 6'd17;
      4'd7:    v = 6'd19;
      4'd8:    v = 6'd23;
      4'd9:    v = 6'd29;
      4'd10:   v = 6'd31;
      4'd11:   v = 6'd37;
      default: v = 6'd37;
    endcase
    return v;
  endfunction
endpackage
`default_nettype wire

// File: hw/rtl/miller_rabin_prime_test_unit.sv
// Top level of the Miller-Rabin prime test unit: sequencer and shared
// shift-add modular multiplier. Depends on mrpt_pkg.
`default_nettype none
// Tests one unsigned candidate (low NUM_BITS bits used) for primality with
// the twelve witness bases 2 to 37, exact for every value below 2^64. One
// transfer in gives one transfer out. The block takes one candidate at a
// time; s_tready is low while it works. Every modular product goes through
// one shared multiplier that processes one multiplier bit per cycle. A
// base needs at most about 2*NUM_BITS products; a prime above 37 runs all
// twelve bases, and most composites finish far sooner. The result waits in
// an output register, so the next candidate can be accepted and worked on
// while it waits; that candidate's result is held back until the earlier
// one has been taken.
module miller_rabin_prime_test_unit
  import mrpt_pkg::*;
#(
  parameter int NUM_BITS = DefNumBits
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,   // candidate
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata    // prime flag, then zero fill
);
  localparam int W  = NUM_BITS;
  localparam int CW = $clog2(W + 1);

  typedef enum logic [3:0] {
    IDLE, SPLIT, BASE, POW_STEP, POW_MUL, POW_SQR, CHECK, SQ_MUL, SQ_CHECK,
    MUL_RUN, DONE
  } state_t;

  state_t state, ret_state;
  logic [W-1:0] n, nm1, odd, e, b, x;
  logic [CW-1:0] twos, k;
  logic [BaseIdxW-1:0] bidx;
  logic result;
  logic verdict;

  // Shared multiplier operands and state.
  logic [W-1:0] ma, mb, acc;
  logic [CW-1:0] mbit;
  logic [W:0] dbl, dsum;
  logic [W-1:0] dred, sred;

  always_comb begin
    dbl  = {acc, 1'b0};
    dred = (dbl >= {1'b0, n}) ? W'(dbl - {1'b0, n}) : dbl[W-1:0];
    dsum = {1'b0, dred} + {1'b0, ma};
    sred = (dsum >= {1'b0, n}) ? W'(dsum - {1'b0, n}) : dsum[W-1:0];
  end

  assign s_tready = (state == IDLE);
  assign m_tdata  = {7'd0, verdict};

  logic [W-1:0] base_w;
  assign base_w = W'(base_value(bidx)) ;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      unique case (state)
        IDLE: if (s_tvalid && s_tready) begin
          n     <= s_tdata[W-1:0];
          nm1   <= s_tdata[W-1:0] - W'(1);
          odd   <= s_tdata[W-1:0] - W'(1);
          twos  <= '0;
          bidx  <= '0;
          if (s_tdata[W-1:0] < W'(2)) begin
            result <= 1'b0;
            state  <= DONE;
          end else begin
            state <= SPLIT;
          end
        end
        SPLIT: begin
          if (!odd[0]) begin
            odd  <= odd >> 1;
            twos <= twos + CW'(1);
          end else begin
            state <= BASE;
          end
        end
        BASE: begin
          if (bidx == BaseIdxW'(BaseCount)) begin
            result <= 1'b1;
            state  <= DONE;
          end else if (n == base_w) begin
            result <= 1'b1;
            state  <= DONE;
          end else begin
            // Every candidate that gets this far exceeds the base: primes
            // below 37 are bases themselves, and composites below 37 already
            // fail with base 2.
            b     <= base_w;
            x     <= W'(1);
            e     <= odd;
            state <= POW_STEP;
          end
        end
        POW_STEP: begin
          if (e == '0) begin
            state <= CHECK;
          end else if (e[0]) begin
            ma <= b; mb <= x; acc <= '0; mbit <= CW'(W);
            ret_state <= POW_MUL; state <= MUL_RUN;
          end else begin
            ma <= b; mb <= b; acc <= '0; mbit <= CW'(W);
            ret_state <= POW_SQR; state <= MUL_RUN;
          end
        end
        POW_MUL: begin
          x  <= acc;
          ma <= b; mb <= b; acc <= '0; mbit <= CW'(W);
          ret_state <= POW_SQR; state <= MUL_RUN;
        end
        POW_SQR: begin
          b     <= acc;
          e     <= e >> 1;
          state <= POW_STEP;
        end
        CHECK: begin
          k <= CW'(1);
          if (x == W'(1) || x == nm1) begin
            bidx <= bidx + BaseIdxW'(1);
            state <= BASE;
          end else begin
            state <= SQ_MUL;
          end
        end
        SQ_MUL: begin
          if (k >= twos) begin
            result <= 1'b0;
            state  <= DONE;
          end else begin
            ma <= x; mb <= x; acc <= '0; mbit <= CW'(W);
            ret_state <= SQ_CHECK; state <= MUL_RUN;
          end
        end
        SQ_CHECK: begin
          x <= acc;
          k <= k + CW'(1);
          if (acc == nm1) begin
            bidx <= bidx + BaseIdxW'(1);
            state <= BASE;
          end else begin
            state <= SQ_MUL;
          end
        end
        MUL_RUN: begin
          // One multiplier bit per cycle, most significant first.
          if (mbit == '0) begin
            state <= ret_state;
          end else begin
            acc  <= mb[W-1] ? sred : dred;
            mb   <= mb << 1;
            mbit <= mbit - CW'(1);
          end
        end
        DONE: begin
          if (!m_tvalid) begin
            verdict  <= result;
            m_tvalid <= 1'b1;
            state    <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
